FILE: src/nsic_pkg.sv
package nsic_pkg;

  localparam int MAX_ITEMS  = 1024;
  localparam int VALUE_BITS = 16;
  localparam int IDX_W      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W      = IDX_W + 1;
  localparam int COUNT_W    = 19;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // one sequence element traveling down the chain
  typedef struct packed {
    logic                  vld;
    logic                  active;  // still to be compared / stored
    logic                  last;
    logic                  ovf;
    logic [IDX_W-1:0]      rem;     // cells left before its own slot
    logic [IDX_W-1:0]      hits;
    logic [VALUE_BITS-1:0] value;
  } token_t;

endpackage

FILE: src/nsic_cell.sv
module nsic_cell import nsic_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  token_t tok_prev,
  output token_t tok
);

  logic [VALUE_BITS-1:0] stored;
  token_t                tok_next;
  logic                  hit;
  logic                  take;

  always_comb begin
    tok_next = tok_prev;
    hit      = (stored >= tok_prev.value);
    take     = 1'b0;
    if (tok_prev.vld && tok_prev.active) begin
      if (tok_prev.rem == '0) begin
        take            = 1'b1;
        tok_next.active = 1'b0;
      end else begin
        tok_next.rem  = tok_prev.rem - 1'b1;
        tok_next.hits = tok_prev.hits + IDX_W'(hit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.vld <= 1'b0;
    end else if (advance) begin
      tok <= tok_next;
      if (take) begin
        stored <= tok_prev.value;
      end
    end
  end

endmodule

FILE: src/nsic_tail.sv
module nsic_tail import nsic_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  token_t             tok,
  input  logic               result_ready,
  output logic               advance,
  output logic               result_valid,
  output logic [COUNT_W-1:0] pair_count,
  output logic               overflow
);

  logic [COUNT_W-1:0] acc;
  logic [COUNT_W-1:0] acc_next;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] sum_sat;
  logic               load;

  assign advance = !result_valid || result_ready;
  assign load    = advance && tok.vld && tok.last;

  always_comb begin
    sum     = {1'b0, acc} + (COUNT_W + 1)'(tok.hits);
    sum_sat = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
    acc_next = acc;
    if (advance && tok.vld) begin
      acc_next = tok.last ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      result_valid <= 1'b0;
    end else begin
      acc <= acc_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
    if (load) begin
      pair_count <= sum_sat;
      overflow   <= tok.ovf;
    end
  end

endmodule

FILE: src/non_strict_inversion_count_unit.sv
// Throughput: one item per cycle; each item walks the full chain of MAX_ITEMS cells,
// one cell per cycle, and the whole chain holds while a result waits on result_ready.
// Reset (rst, synchronous, active high) empties the chain and clears fill count, the
// overflow flag and running count; stored values, pair_count and overflow are kept.
module non_strict_inversion_count_unit import nsic_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  last,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [COUNT_W-1:0]    pair_count,
  output logic                  overflow
);

  logic             advance;
  logic [CNT_W-1:0] fill_cnt;
  logic [CNT_W-1:0] fill_cnt_next;
  logic             ovf_seen;
  logic             ovf_seen_next;
  logic             full;
  logic             xfer;
  token_t           tok_in;
  token_t           chain [MAX_ITEMS+1];

  assign item_ready = advance && !rst;
  assign xfer       = item_valid && item_ready;
  assign full       = (fill_cnt == CNT_W'(MAX_ITEMS));

  always_comb begin
    tok_in.vld    = item_valid;
    tok_in.active = !full;
    tok_in.last   = last;
    tok_in.ovf    = ovf_seen || full;
    tok_in.rem    = fill_cnt[IDX_W-1:0];
    tok_in.hits   = '0;
    tok_in.value  = value;
  end

  always_comb begin
    fill_cnt_next = fill_cnt;
    ovf_seen_next = ovf_seen;
    if (xfer) begin
      if (last) begin
        fill_cnt_next = '0;
        ovf_seen_next = 1'b0;
      end else if (full) begin
        ovf_seen_next = 1'b1;
      end else begin
        fill_cnt_next = fill_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= '0;
      ovf_seen <= 1'b0;
    end else begin
      fill_cnt <= fill_cnt_next;
      ovf_seen <= ovf_seen_next;
    end
  end

  assign chain[0] = tok_in;

  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    nsic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .tok_prev (chain[k]),
      .tok      (chain[k+1])
    );
  end

  nsic_tail u_tail (
    .clk          (clk),
    .rst          (rst),
    .tok          (chain[MAX_ITEMS]),
    .result_ready (result_ready),
    .advance      (advance),
    .result_valid (result_valid),
    .pair_count   (pair_count),
    .overflow     (overflow)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_cnt <= CNT_W'(MAX_ITEMS))
    else $error("fill count beyond capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf_seen |-> full)
    else $error("overflow flagged while store not full");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (xfer && last) |=> (fill_cnt == '0) && !ovf_seen)
    else $error("sequence state not cleared after last");

endmodule
